// ===== rtl/lobm_pkg.sv =====
// Shared types, sizes, codes and bit-search helpers for the order book matcher.
package lobm_pkg;

  localparam int NUM_LEVELS  = 1024;
  localparam int LEVEL_DEPTH = 16;
  localparam int TICK_W      = $clog2(NUM_LEVELS);
  localparam int POS_W       = $clog2(LEVEL_DEPTH);
  localparam int LV_W        = TICK_W + 1;
  localparam int SLOT_AW     = LV_W + POS_W;
  localparam int TOTAL_LV    = 2 * NUM_LEVELS;
  localparam int TOTAL_SLOTS = TOTAL_LV * LEVEL_DEPTH;
  localparam int CNT_W       = POS_W + 1;
  localparam int BIT_W       = 5;
  localparam int WORD_BITS   = 1 << BIT_W;
  localparam int WORD_W      = TICK_W - BIT_W;
  localparam int NUM_WORDS   = 1 << WORD_W;
  localparam int OCC_AW      = WORD_W + 1;
  localparam int QTY_W       = 16;
  localparam int ID_W        = 31;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_CANCEL = 1'b1;

  localparam logic [2:0] ST_RESTED    = 3'd0;
  localparam logic [2:0] ST_FILLED    = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOTFOUND  = 3'd3;
  localparam logic [2:0] ST_DROPPED   = 3'd4;

  typedef struct packed {
    logic             action;
    logic [ID_W-1:0]  order_id;
    logic [TICK_W-1:0] price_tick;
    logic [QTY_W-1:0] quantity;
    logic             side;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [QTY_W-1:0]  filled_qty;
    logic [QTY_W-1:0]  rested_qty;
    logic [TICK_W-1:0] best_bid;
    logic              best_bid_valid;
    logic [TICK_W-1:0] best_ask;
    logic              best_ask_valid;
  } out_item_t;

  // Classified entry passed from the front queue to the engine
  typedef struct packed {
    logic     cancel;
    in_item_t item;
  } q_item_t;

  typedef struct packed {
    logic [POS_W-1:0] head;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] live;
  } meta_t;

  function automatic logic [BIT_W-1:0] hi_idx(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] lo_idx(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] hi_word(input logic [NUM_WORDS-1:0] v);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (v[i]) r = WORD_W'(i);
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] lo_word(input logic [NUM_WORDS-1:0] v);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (v[i]) r = WORD_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== rtl/lobm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lobm_front.sv =====
// Front end: two-entry input queue that takes transactions and classifies them.
module lobm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              hold,
  input  logic              in_valid,
  output logic              in_ready,
  input  lobm_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output lobm_pkg::q_item_t q_item
);
  import lobm_pkg::*;

  q_item_t    ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = ent[rp];

  // Store the classified transaction
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp].cancel <= (in_data.action == ACT_CANCEL);
      ent[wp].item   <= in_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/lobm_engine.sv =====
// Back end: sequencer that matches, rests and cancels orders and reports best prices.
module lobm_engine (
  input  logic                clk,
  input  logic                rst,
  output logic                clearing,
  input  logic                q_valid,
  output logic                q_pop,
  input  lobm_pkg::q_item_t   q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output lobm_pkg::out_item_t out_data
);
  import lobm_pkg::*;

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_MATCH  = 5'd2;
  localparam logic [4:0] S_SRCH   = 5'd3;
  localparam logic [4:0] S_SRCH2  = 5'd4;
  localparam logic [4:0] S_DISP   = 5'd5;
  localparam logic [4:0] S_MRD    = 5'd6;
  localparam logic [4:0] S_MGET   = 5'd7;
  localparam logic [4:0] S_FRD    = 5'd8;
  localparam logic [4:0] S_FUPD   = 5'd9;
  localparam logic [4:0] S_TRIM   = 5'd10;
  localparam logic [4:0] S_TRD    = 5'd11;
  localparam logic [4:0] S_TCHK   = 5'd12;
  localparam logic [4:0] S_OCLR   = 5'd13;
  localparam logic [4:0] S_OSET   = 5'd14;
  localparam logic [4:0] S_CRD    = 5'd15;
  localparam logic [4:0] S_CCHK   = 5'd16;
  localparam logic [4:0] S_FINAL  = 5'd17;
  localparam logic [4:0] S_OUT    = 5'd18;

  localparam logic [1:0] PH_MATCH = 2'd0;
  localparam logic [1:0] PH_REST  = 2'd1;
  localparam logic [1:0] PH_BID   = 2'd2;
  localparam logic [1:0] PH_ASK   = 2'd3;

  localparam int CLR_W = $clog2(TOTAL_LV);

  logic [4:0]         state;
  logic [CLR_W-1:0]   cnt;
  logic               cancel;
  logic [ID_W-1:0]    id;
  logic [TICK_W-1:0]  price;
  logic               side;
  logic [QTY_W-1:0]   rem;
  logic [QTY_W-1:0]   filled;
  logic [QTY_W-1:0]   rested;
  logic [2:0]         status;
  logic [LV_W-1:0]    lv;
  logic [POS_W-1:0]   head;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   live;
  logic [CNT_W-1:0]   k;
  logic               srch_side;
  logic [1:0]         phase;
  logic [WORD_W-1:0]  srch_w;
  logic               found;
  logic [TICK_W-1:0]  tick;
  logic [TICK_W-1:0]  bid;
  logic               bid_ok;
  logic [1:0][NUM_WORDS-1:0] summ;

  // RAM ports
  logic               meta_we;
  meta_t              meta_wdata;
  meta_t              meta_rdata;
  logic               qty_we;
  logic               id_we;
  logic [SLOT_AW-1:0] slot_waddr;
  logic [SLOT_AW-1:0] slot_raddr;
  logic [QTY_W-1:0]   qty_wdata;
  logic [QTY_W-1:0]   qty_rdata;
  logic [ID_W-1:0]    id_rdata;
  logic               occ_we;
  logic [OCC_AW-1:0]  occ_waddr;
  logic [WORD_BITS-1:0] occ_wdata;
  logic [OCC_AW-1:0]  occ_raddr;
  logic [WORD_BITS-1:0] occ_rdata;
  logic [LV_W-1:0]    meta_waddr;

  // Derived values
  logic [NUM_WORDS-1:0] cur_summ;
  logic [WORD_W-1:0]    pick_w;
  logic [BIT_W-1:0]     pick_b;
  logic [QTY_W-1:0]     fill_amt;
  logic [QTY_W-1:0]     q_left;
  logic [POS_W-1:0]     pos;
  logic [WORD_BITS-1:0] lv_bit;
  logic                 crosses;
  logic                 out_free;

  assign clearing  = (state == S_CLEAR);
  assign cur_summ  = summ[srch_side];
  assign pick_w    = srch_side ? lo_word(cur_summ) : hi_word(cur_summ);
  assign pick_b    = srch_side ? lo_idx(occ_rdata) : hi_idx(occ_rdata);
  assign fill_amt  = (qty_rdata < rem) ? qty_rdata : rem;
  assign q_left    = qty_rdata - fill_amt;
  assign pos       = head + k[POS_W-1:0];
  assign lv_bit    = WORD_BITS'(1) << lv[BIT_W-1:0];
  assign crosses   = found && (side ? (tick >= price) : (tick <= price));
  assign out_free  = !out_valid || out_ready;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign slot_raddr = {lv, pos};
  assign meta_waddr = clearing ? cnt : lv;

  // Drive RAM controls from the current step
  always_comb begin
    meta_we    = 1'b0;
    meta_wdata = '0;
    qty_we     = 1'b0;
    id_we      = 1'b0;
    slot_waddr = {lv, pos};
    qty_wdata  = '0;
    occ_we     = 1'b0;
    occ_waddr  = {lv[LV_W-1], lv[TICK_W-1:BIT_W]};
    occ_wdata  = '0;
    occ_raddr  = {lv[LV_W-1], lv[TICK_W-1:BIT_W]};
    case (state)
      S_CLEAR: begin
        meta_we   = 1'b1;
        occ_we    = 1'b1;
        occ_waddr = cnt[OCC_AW-1:0];
      end
      S_SRCH: begin
        occ_raddr = {srch_side, pick_w};
      end
      S_MGET: begin
        if (!cancel && phase == PH_REST && meta_rdata.used < CNT_W'(LEVEL_DEPTH)) begin
          qty_we     = 1'b1;
          id_we      = 1'b1;
          slot_waddr = {lv, meta_rdata.head + meta_rdata.used[POS_W-1:0]};
          qty_wdata  = rem;
          meta_we    = 1'b1;
          meta_wdata = '{head: meta_rdata.head, used: meta_rdata.used + CNT_W'(1),
                         live: meta_rdata.live + CNT_W'(1)};
        end
      end
      S_FUPD: begin
        if (qty_rdata != '0) begin
          qty_we    = 1'b1;
          qty_wdata = q_left;
        end
      end
      S_TRIM: begin
        if (live == '0) meta_we = 1'b1;
      end
      S_TRD: begin
        if (used == '0) begin
          meta_we    = 1'b1;
          meta_wdata = '{head: head, used: used, live: live};
        end
      end
      S_TCHK: begin
        if (qty_rdata != '0) begin
          meta_we    = 1'b1;
          meta_wdata = '{head: head, used: used, live: live};
        end
      end
      S_OCLR: begin
        occ_we    = 1'b1;
        occ_wdata = occ_rdata & ~lv_bit;
      end
      S_OSET: begin
        occ_we    = 1'b1;
        occ_wdata = occ_rdata | lv_bit;
      end
      S_CCHK: begin
        if (qty_rdata != '0 && id_rdata == id) begin
          qty_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence one transaction at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      summ      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + CLR_W'(1);
          if (cnt == CLR_W'(TOTAL_LV - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cancel <= q_item.cancel;
            id     <= q_item.item.order_id;
            price  <= q_item.item.price_tick;
            side   <= q_item.item.side;
            rem    <= q_item.item.quantity;
            filled <= '0;
            rested <= '0;
            lv     <= {q_item.item.side, q_item.item.price_tick};
            state  <= q_item.cancel ? S_MRD : S_MATCH;
          end
        end
        S_MATCH: begin
          phase     <= PH_MATCH;
          srch_side <= ~side;
          if (rem == '0) begin
            status <= ST_FILLED;
            state  <= S_FINAL;
          end else begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          srch_w <= pick_w;
          if (cur_summ == '0) begin
            found <= 1'b0;
            tick  <= '0;
            state <= S_DISP;
          end else begin
            state <= S_SRCH2;
          end
        end
        S_SRCH2: begin
          tick  <= {srch_w, pick_b};
          found <= 1'b1;
          state <= S_DISP;
        end
        S_DISP: begin
          case (phase)
            PH_MATCH: begin
              if (crosses) begin
                lv <= {~side, tick};
              end else begin
                lv    <= {side, price};
                phase <= PH_REST;
              end
              state <= S_MRD;
            end
            PH_BID: begin
              bid       <= tick;
              bid_ok    <= found;
              srch_side <= 1'b1;
              phase     <= PH_ASK;
              state     <= S_SRCH;
            end
            default: state <= S_OUT;
          endcase
        end
        S_MRD: state <= S_MGET;
        S_MGET: begin
          head <= meta_rdata.head;
          used <= meta_rdata.used;
          live <= meta_rdata.live;
          k    <= '0;
          if (cancel) begin
            state <= S_CRD;
          end else if (phase == PH_REST) begin
            if (meta_rdata.used < CNT_W'(LEVEL_DEPTH)) begin
              status <= ST_RESTED;
              rested <= rem;
              state  <= S_OSET;
            end else begin
              status <= ST_DROPPED;
              state  <= S_FINAL;
            end
          end else begin
            state <= S_FRD;
          end
        end
        S_FRD: begin
          state <= (k < used && rem != '0) ? S_FUPD : S_TRIM;
        end
        S_FUPD: begin
          if (qty_rdata != '0) begin
            rem    <= rem - fill_amt;
            filled <= filled + fill_amt;
            if (q_left == '0) live <= live - CNT_W'(1);
          end
          k     <= k + CNT_W'(1);
          state <= S_FRD;
        end
        S_TRIM: begin
          k     <= '0;
          state <= (live == '0) ? S_OCLR : S_TRD;
        end
        S_TRD: begin
          if (used == '0) state <= cancel ? S_FINAL : S_MATCH;
          else state <= S_TCHK;
        end
        S_TCHK: begin
          if (qty_rdata == '0) begin
            head  <= head + POS_W'(1);
            used  <= used - CNT_W'(1);
            state <= S_TRD;
          end else begin
            state <= cancel ? S_FINAL : S_MATCH;
          end
        end
        S_OCLR: begin
          summ[lv[LV_W-1]][lv[TICK_W-1:BIT_W]] <= ((occ_rdata & ~lv_bit) != '0);
          state <= cancel ? S_FINAL : S_MATCH;
        end
        S_OSET: begin
          summ[lv[LV_W-1]][lv[TICK_W-1:BIT_W]] <= 1'b1;
          state <= S_FINAL;
        end
        S_CRD: begin
          if (k < used) begin
            state <= S_CCHK;
          end else begin
            status <= ST_NOTFOUND;
            state  <= S_FINAL;
          end
        end
        S_CCHK: begin
          if (qty_rdata != '0 && id_rdata == id) begin
            live   <= live - CNT_W'(1);
            status <= ST_CANCELLED;
            state  <= S_TRIM;
          end else begin
            k     <= k + CNT_W'(1);
            state <= S_CRD;
          end
        end
        S_FINAL: begin
          phase     <= PH_BID;
          srch_side <= 1'b0;
          state     <= S_SRCH;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid               <= 1'b1;
            out_data.status         <= status;
            out_data.filled_qty     <= filled;
            out_data.rested_qty     <= rested;
            out_data.best_bid       <= bid;
            out_data.best_bid_valid <= bid_ok;
            out_data.best_ask       <= tick;
            out_data.best_ask_valid <= found;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lobm_ram #(.WIDTH($bits(meta_t)), .DEPTH(TOTAL_LV)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(lv), .rdata(meta_rdata)
  );

  lobm_ram #(.WIDTH(QTY_W), .DEPTH(TOTAL_SLOTS)) u_qty (
    .clk(clk), .we(qty_we), .waddr(slot_waddr), .wdata(qty_wdata),
    .raddr(slot_raddr), .rdata(qty_rdata)
  );

  lobm_ram #(.WIDTH(ID_W), .DEPTH(TOTAL_SLOTS)) u_id (
    .clk(clk), .we(id_we), .waddr(slot_waddr), .wdata(id),
    .raddr(slot_raddr), .rdata(id_rdata)
  );

  lobm_ram #(.WIDTH(WORD_BITS), .DEPTH(2 * NUM_WORDS)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
    .raddr(occ_raddr), .rdata(occ_rdata)
  );

endmodule

// ===== rtl/limit_order_book_matcher_unit.sv =====
// Top level of the price-time priority limit order book matcher.
// Each transaction (insert or cancel) yields one result carrying its status,
// filled and rested quantities and the best bid and ask afterwards. Items are
// handled one at a time by a sequencer behind a two-entry input queue; a
// result register lets the next item start while a result waits. After reset
// a clearing pass over all 2048 levels zeroes the level table, and no item is
// taken until it ends. Each item is taken and processed, then the closing
// best-bid and best-ask searches run before its result is handed off. An insert
// searches the opposite side once per level traded, plus once more that finds
// no crossing level unless its quantity runs out; for each level traded it
// reads the level and visits its slots, then clears the level's occupancy bit
// if the level empties, else trims holes at its head; it then stops if its
// quantity ran out, else rests the remainder or drops it when the level is
// full. A cancel searches the level's slots for the order and, when it finds
// it, clears the occupancy bit if the level empties, else trims holes.
module limit_order_book_matcher_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lobm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lobm_pkg::out_item_t out_data
);
  import lobm_pkg::*;

  logic    clearing;
  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  lobm_front u_front (
    .clk(clk), .rst(rst), .hold(clearing),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  lobm_engine u_engine (
    .clk(clk), .rst(rst), .clearing(clearing),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
